/* rtl/core/spq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, codes and default sizes for the sorted priority queue cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Default number of key cells and key width.
    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 8;

    // Command codes carried by the cmd field.
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } cmd_t;

    // Status codes reported with every result.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Operation strobes broadcast to every cell.
    typedef struct packed {
        logic ins_en;
        logic del_en;
    } op_t;

    // Compare flags that each cell reports about its own key.
    typedef struct packed {
        logic gt;     // the command key goes in front of this cell's key
        logic le;     // this cell's key is not above the command key
        logic match;  // this cell holds a valid key equal to the command key
    } flag_t;

endpackage

/* rtl/core/spq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one key, compares it against the broadcast key and shifts toward
// the tail on insert or toward the head on delete.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF
) (
    input  logic                clk,
    input  spq_pkg::op_t        op,
    input  logic [KEY_BITS-1:0] new_key,
    input  logic                cell_valid,
    input  logic                left_gt,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [KEY_BITS-1:0] right_key,
    output spq_pkg::flag_t      flag,
    output logic [KEY_BITS-1:0] key,
    output logic [KEY_BITS-1:0] key_next
);

    logic [KEY_BITS-1:0] key_reg;

    // Local compares against the broadcast key.
    always_comb
    begin
        flag.gt    = !cell_valid || (new_key > key_reg);
        flag.le    = key_reg <= new_key;
        flag.match = cell_valid && (key_reg == new_key);
    end

    // Insert takes the left key when the left cell moved, or the new key at
    // the insertion point. Delete pulls the right key from the match onward.
    always_comb
    begin
        key_next = key_reg;
        if (op.ins_en)
        begin
            if (left_gt)
            begin
                key_next = left_key;
            end
            else if (flag.gt)
            begin
                key_next = new_key;
            end
        end
        else if (op.del_en && cell_valid && flag.le)
        begin
            key_next = right_key;
        end
    end

    // Key storage needs no reset; only cells below the count are read.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

/* rtl/core/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue
// Ordered key store built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Keys are held largest first in a row of DEPTH cells, each comparing its own
// key with the command key and shifting to a neighbor in the same cycle. An
// insert lands after any equal keys; a delete removes the first equal key and
// closes the gap. Each command is accepted, all cells update at once, and the
// result sits in an output register the next cycle.
// A new command is accepted in every cycle while the result side takes its
// transfers, and held off only while a finished result is stalled. The
// delete path includes an OR over all cells' match flags, which sets the
// cycle time for large DEPTH.
module sorted_priority_queue #(
    parameter int DEPTH    = spq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
    localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  logic [KEY_BITS-1:0] key_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [CNT_BITS-1:0] entry_count,
    output logic                head_valid,
    output logic [KEY_BITS-1:0] head_key
);

    logic                  in_accept;
    logic                  is_delete;
    logic                  full;
    logic                  found;
    spq_pkg::op_t          op;
    spq_pkg::status_t      status_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [CNT_BITS-1:0]   cnt_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    spq_pkg::status_t      status_reg;
    logic [CNT_BITS-1:0]   count_out_reg;
    logic                  head_valid_reg;
    logic [KEY_BITS-1:0]   head_key_reg;
    logic [KEY_BITS-1:0]   head_key_next;

    spq_pkg::flag_t        flags [DEPTH];
    logic [KEY_BITS-1:0]   keys [DEPTH];
    logic [KEY_BITS-1:0]   keys_next [DEPTH];
    logic [DEPTH-1:0]      match_vec;

    // A new command is taken unless a finished result is held by the sink.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign is_delete = (cmd == spq_pkg::CMD_DELETE);
    assign full      = (cnt_reg == CNT_BITS'(DEPTH));
    assign found     = |match_vec;

    // Row of cells; the first cell sees no moving left neighbor and the last
    // cell pulls in a zero key on delete.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                cell_valid;
        logic                left_gt;
        logic [KEY_BITS-1:0] left_key;
        logic [KEY_BITS-1:0] right_key;

        assign cell_valid   = cnt_reg > CNT_BITS'(i);
        assign match_vec[i] = flags[i].match;

        if (i == 0)
        begin : g_first
            assign left_gt  = 1'b0;
            assign left_key = '0;
        end
        else
        begin : g_inner
            assign left_gt  = flags[i-1].gt;
            assign left_key = keys[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_key = '0;
        end
        else
        begin : g_body
            assign right_key = keys[i+1];
        end

        spq_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .new_key    (key_value),
            .cell_valid (cell_valid),
            .left_gt    (left_gt),
            .left_key   (left_key),
            .right_key  (right_key),
            .flag       (flags[i]),
            .key        (keys[i]),
            .key_next   (keys_next[i])
        );
    end

    // Command decode, status and next count.
    always_comb
    begin
        op.ins_en   = 1'b0;
        op.del_en   = 1'b0;
        status_next = spq_pkg::ST_OK;
        cnt_next    = cnt_reg;
        if (!is_delete)
        begin
            if (full)
            begin
                status_next = spq_pkg::ST_OVERFLOW;
            end
            else
            begin
                op.ins_en = in_accept;
                cnt_next  = cnt_reg + CNT_BITS'(1);
            end
        end
        else if (cnt_reg == '0)
        begin
            status_next = spq_pkg::ST_EMPTY;
        end
        else if (!found)
        begin
            status_next = spq_pkg::ST_NOTFOUND;
        end
        else
        begin
            op.del_en = in_accept;
            cnt_next  = cnt_reg - CNT_BITS'(1);
        end
        head_key_next = (cnt_next != '0) ? keys_next[0] : '0;
    end

    // Output register handover.
    always_comb
    begin
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // Control state: count and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // Result payload, loaded on each accepted command.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            status_reg     <= status_next;
            count_out_reg  <= cnt_next;
            head_valid_reg <= (cnt_next != '0);
            head_key_reg   <= head_key_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = count_out_reg;
    assign head_valid  = head_valid_reg;
    assign head_key    = head_key_reg;

    // The count never passes the number of cells.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(DEPTH))
    else $error("key count exceeds depth");

    // An insert into a store that is not full grows the count by one.
    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !is_delete && !full) |=> (cnt_reg == $past(cnt_reg) + CNT_BITS'(1)))
    else $error("insert did not grow the count");

    // The first two stored keys stay in order, largest first.
    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg > CNT_BITS'(1)) |-> (keys[0] >= keys[1]))
    else $error("stored keys out of order");

    // An overflow result always reports a full store.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == spq_pkg::ST_OVERFLOW))
            |-> (count_out_reg == CNT_BITS'(DEPTH)))
    else $error("overflow reported on a store that is not full");

endmodule
